[rtl/msf_pkg.sv]
// ----------------------------------------------------------------------------
// msf_pkg: shared types and constants for the masked signal filter
// Slot table sizing, command codes, result kinds and sequencer states.
// ----------------------------------------------------------------------------
package msf_pkg;

	// table sizing
	localparam int SLOT_COUNT    = 16;
	localparam int SIGNAL_WIDTH  = 32;
	localparam int TIMEOUT_WIDTH = 16;
	localparam int IDX_W         = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	// port field widths
	localparam int CMD_W     = 2;
	localparam int SIG_W     = 32;
	localparam int TICKS_W   = 16;
	localparam int SLOT_W    = 4;

	typedef enum logic [CMD_W-1:0] {
		CMD_SIGNAL = 2'd0,
		CMD_TICK   = 2'd1,
		CMD_ADD    = 2'd2,
		CMD_REMOVE = 2'd3
	} cmd_t;

	typedef enum logic {
		EV_DELIVER = 1'b0,
		EV_TIMEOUT = 1'b1
	} event_kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH
	} state_t;

endpackage

[rtl/masked_signal_filter_with_timeouts.sv]
// ----------------------------------------------------------------------------
// masked_signal_filter_with_timeouts: subscription slot table with timeouts
// Add and remove update the table when accepted. Signal and tick items scan one slot
// per cycle while the output register is free, through a shared compare/decrement unit;
// a new item is accepted only once the scan and flush of the last one are done.
// Results appear in the cycle after the scan step that finds the next hit, or after the flush.
// Reset (arst_n low, asynchronous) clears all slots, countdowns and the output valid flag.
// ----------------------------------------------------------------------------
module masked_signal_filter_with_timeouts (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [msf_pkg::CMD_W-1:0]   command,
	input  logic [msf_pkg::SIG_W-1:0]   signal_id,
	input  logic [msf_pkg::SIG_W-1:0]   filter_mask,
	input  logic [msf_pkg::TICKS_W-1:0] timeout_ticks,
	input  logic [msf_pkg::SLOT_W-1:0]  slot_index,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        event_kind,
	output logic [msf_pkg::SLOT_W-1:0]  hit_slot,
	output logic [msf_pkg::SIG_W-1:0]   delivered_signal,
	output logic                        last_of_run
);
	import msf_pkg::*;

	localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOT_COUNT - 1);

	// slot table
	logic                     slot_valid_q [SLOT_COUNT];
	logic [SIGNAL_WIDTH-1:0]  match_value_q [SLOT_COUNT];
	logic [SIGNAL_WIDTH-1:0]  match_mask_q [SLOT_COUNT];
	logic [TIMEOUT_WIDTH-1:0] timeout_length_q [SLOT_COUNT];
	logic [TIMEOUT_WIDTH-1:0] countdown_q [SLOT_COUNT];
	logic                     armed_q [SLOT_COUNT];

	// sequencer
	state_t                  state_q, state_d;
	cmd_t                    cmd_q;
	logic [SIGNAL_WIDTH-1:0] sig_q;
	logic [IDX_W-1:0]        scan_idx_q;

	// held hit waiting to learn whether it is the last one
	logic                    hold_valid_q;
	event_kind_t             hold_kind_q;
	logic [IDX_W-1:0]        hold_slot_q;
	logic [SIGNAL_WIDTH-1:0] hold_sig_q;

	// output register
	logic                    out_valid_q;
	event_kind_t             out_kind_q;
	logic [SLOT_W-1:0]       out_slot_q;
	logic [SIG_W-1:0]        out_sig_q;
	logic                    out_last_q;

	// control
	logic                     accept;
	logic                     out_free;
	logic                     step_en;
	logic                     flush_en;
	logic                     in_range;
	logic [IDX_W-1:0]         wr_idx;
	logic [SIGNAL_WIDTH-1:0]  in_sig;
	logic [SIGNAL_WIDTH-1:0]  in_msk;
	logic [31:0]              tmo_ext;
	logic [TIMEOUT_WIDTH-1:0] in_tmo;

	// shared unit
	logic                     cur_valid;
	logic                     sig_match;
	logic [TIMEOUT_WIDTH-1:0] cnt_dec;
	logic                     tick_hit;
	logic                     hit;
	event_kind_t              hit_kind;
	logic [SIGNAL_WIDTH-1:0]  hit_sig;

	// input field shaping
	assign accept   = in_valid && in_ready;
	assign in_range = (int'(slot_index) < SLOT_COUNT);
	assign wr_idx   = IDX_W'(slot_index);
	assign in_sig   = signal_id[SIGNAL_WIDTH-1:0];
	assign in_msk   = filter_mask[SIGNAL_WIDTH-1:0];
	assign tmo_ext  = 32'(timeout_ticks);
	assign in_tmo   = tmo_ext[TIMEOUT_WIDTH-1:0];

	// compare and decrement the slot under the scan pointer
	assign cur_valid = slot_valid_q[scan_idx_q];
	assign sig_match = cur_valid &&
		((sig_q & match_mask_q[scan_idx_q]) == match_value_q[scan_idx_q]);
	assign cnt_dec   = countdown_q[scan_idx_q] - TIMEOUT_WIDTH'(1);
	assign tick_hit  = cur_valid && armed_q[scan_idx_q] && (cnt_dec == '0);
	assign hit       = (cmd_q == CMD_SIGNAL) ? sig_match : tick_hit;
	assign hit_kind  = (cmd_q == CMD_SIGNAL) ? EV_DELIVER : EV_TIMEOUT;
	assign hit_sig   = (cmd_q == CMD_SIGNAL) ? sig_q : '0;

	assign out_free = !out_valid_q || out_ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (cmd_t'(command) == CMD_SIGNAL ||
					cmd_t'(command) == CMD_TICK)) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (out_free && scan_idx_q == LAST_SLOT) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (out_free || !hold_valid_q) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready = 1'b0;
		step_en  = 1'b0;
		flush_en = 1'b0;
		unique case (state_q)
			ST_IDLE:  in_ready = 1'b1;
			ST_SCAN:  step_en  = out_free;
			ST_FLUSH: flush_en = out_free && hold_valid_q;
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			scan_idx_q   <= '0;
			hold_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				scan_idx_q <= '0;
			end else if (step_en) begin
				scan_idx_q <= scan_idx_q + IDX_W'(1);
			end
			if (step_en && hit) begin
				hold_valid_q <= 1'b1;
			end else if (flush_en) begin
				hold_valid_q <= 1'b0;
			end
			if ((step_en && hit && hold_valid_q) || flush_en) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd_t'(command);
			sig_q <= in_sig;
		end
		if (step_en && hit) begin
			hold_kind_q <= hit_kind;
			hold_slot_q <= scan_idx_q;
			hold_sig_q  <= hit_sig;
		end
		if ((step_en && hit && hold_valid_q) || flush_en) begin
			out_kind_q <= hold_kind_q;
			out_slot_q <= SLOT_W'(hold_slot_q);
			out_sig_q  <= SIG_W'(hold_sig_q);
			out_last_q <= flush_en;
		end
	end

	// slot contents: written on add only
	always_ff @(posedge clk) begin
		if (accept && in_range && cmd_t'(command) == CMD_ADD) begin
			match_value_q[wr_idx]    <= in_sig;
			match_mask_q[wr_idx]     <= in_msk;
			timeout_length_q[wr_idx] <= in_tmo;
		end
	end

	// valid bits, countdowns and armed bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				slot_valid_q[i] <= 1'b0;
				countdown_q[i]  <= '0;
				armed_q[i]      <= 1'b0;
			end
		end else begin
			if (accept && in_range && cmd_t'(command) == CMD_ADD) begin
				slot_valid_q[wr_idx] <= 1'b1;
				countdown_q[wr_idx]  <= in_tmo;
				armed_q[wr_idx]      <= (in_tmo != '0);
			end else if (accept && in_range && cmd_t'(command) == CMD_REMOVE) begin
				slot_valid_q[wr_idx] <= 1'b0;
				countdown_q[wr_idx]  <= '0;
				armed_q[wr_idx]      <= 1'b0;
			end else if (step_en) begin
				// reload on delivery, count down on tick
				if (cmd_q == CMD_SIGNAL) begin
					if (sig_match && timeout_length_q[scan_idx_q] != '0) begin
						countdown_q[scan_idx_q] <= timeout_length_q[scan_idx_q];
						armed_q[scan_idx_q]     <= 1'b1;
					end
				end else if (cur_valid && armed_q[scan_idx_q]) begin
					countdown_q[scan_idx_q] <= cnt_dec;
					if (cnt_dec == '0) begin
						armed_q[scan_idx_q] <= 1'b0;
					end
				end
			end
		end
	end

	// drive ports
	assign out_valid        = out_valid_q;
	assign event_kind       = out_kind_q;
	assign hit_slot         = out_slot_q;
	assign delivered_signal = out_sig_q;
	assign last_of_run      = out_last_q;

endmodule

[verif/tb_masked_signal_filter_with_timeouts.sv]
// ----------------------------------------------------------------------------
// tb_masked_signal_filter_with_timeouts: self-checking bench for the slot filter
// Drives add, remove, signal and tick items through the input handshake, keeps
// a behavioral copy of the slot table to predict each delivery and timeout
// event, and compares every accepted result field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_masked_signal_filter_with_timeouts;

	import msf_pkg::*;

	localparam int CLK_HALF     = 5;
	localparam int RESET_CYCLES = 12;
	localparam int DRAIN_TAIL   = SLOT_COUNT + 8;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int MAX_REPORTS  = 100;
	localparam int HOLD_CYCLES  = 400;

	typedef struct packed {
		event_kind_t        kind;
		logic [SLOT_W-1:0]  slot;
		logic [SIG_W-1:0]   sig;
		logic               last_flag;
	} slot_event_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [CMD_W-1:0]    command;
	logic [SIG_W-1:0]    signal_id;
	logic [SIG_W-1:0]    filter_mask;
	logic [TICKS_W-1:0]  timeout_ticks;
	logic [SLOT_W-1:0]   slot_index;
	logic                out_valid;
	logic                out_ready;
	logic                event_kind;
	logic [SLOT_W-1:0]   hit_slot;
	logic [SIG_W-1:0]    delivered_signal;
	logic                last_of_run;

	// shadow slot table
	logic                     sub_valid   [SLOT_COUNT];
	logic [SIGNAL_WIDTH-1:0]  sub_value   [SLOT_COUNT];
	logic [SIGNAL_WIDTH-1:0]  sub_mask    [SLOT_COUNT];
	logic [TIMEOUT_WIDTH-1:0] sub_timeout [SLOT_COUNT];
	logic [TIMEOUT_WIDTH-1:0] sub_count   [SLOT_COUNT];
	logic                     sub_armed   [SLOT_COUNT];

	slot_event_t pending_events[$];
	int          err_count;
	int          cycle_count;
	int          in_idle_pct;
	int          out_idle_pct;
	int          hold_request;
	int          hold_left;

	masked_signal_filter_with_timeouts i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.command          (command),
		.signal_id        (signal_id),
		.filter_mask      (filter_mask),
		.timeout_ticks    (timeout_ticks),
		.slot_index       (slot_index),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.event_kind       (event_kind),
		.hit_slot         (hit_slot),
		.delivered_signal (delivered_signal),
		.last_of_run      (last_of_run)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Update the shadow table for one accepted item and queue its events.
	function automatic void predict_slot_events(input cmd_t cmd, input logic [SIG_W-1:0] sig,
			input logic [SIG_W-1:0] msk, input logic [TICKS_W-1:0] tmo,
			input logic [SLOT_W-1:0] idx);
		slot_event_t run_events[$];
		slot_event_t ev;
		case (cmd)
			CMD_SIGNAL: begin
				for (int i = 0; i < SLOT_COUNT; i++) begin
					if (sub_valid[i] && ((sig & sub_mask[i]) == sub_value[i])) begin
						// re-arm, also after an earlier timeout
						if (sub_timeout[i] != '0) begin
							sub_count[i] = sub_timeout[i];
							sub_armed[i] = 1'b1;
						end
						ev.kind      = EV_DELIVER;
						ev.slot      = SLOT_W'(i);
						ev.sig       = sig;
						ev.last_flag = 1'b0;
						run_events.push_back(ev);
					end
				end
			end
			CMD_TICK: begin
				for (int i = 0; i < SLOT_COUNT; i++) begin
					if (sub_valid[i] && sub_armed[i]) begin
						sub_count[i] = sub_count[i] - 1'b1;
						if (sub_count[i] == '0) begin
							sub_armed[i] = 1'b0;
							ev.kind      = EV_TIMEOUT;
							ev.slot      = SLOT_W'(i);
							ev.sig       = '0;
							ev.last_flag = 1'b0;
							run_events.push_back(ev);
						end
					end
				end
			end
			CMD_ADD: begin
				if (idx < SLOT_COUNT) begin
					sub_valid[idx]   = 1'b1;
					sub_value[idx]   = sig;
					sub_mask[idx]    = msk;
					sub_timeout[idx] = tmo;
					sub_count[idx]   = tmo;
					sub_armed[idx]   = (tmo != '0);
				end
			end
			default: begin
				if (idx < SLOT_COUNT) begin
					sub_valid[idx] = 1'b0;
					sub_armed[idx] = 1'b0;
					sub_count[idx] = '0;
				end
			end
		endcase
		// flag the final event of this item
		foreach (run_events[k]) begin
			ev = run_events[k];
			ev.last_flag = (k == run_events.size() - 1);
			pending_events.push_back(ev);
		end
	endfunction

	task automatic report_mismatch(input string field, input logic [SIG_W-1:0] exp_val,
			input logic [SIG_W-1:0] act_val);
		err_count++;
		if (err_count <= MAX_REPORTS)
			$error("%s: expected %h, got %h", field, exp_val, act_val);
	endtask

	// Predict on accepted items and check accepted results at the same edge.
	always @(posedge clk) begin
		slot_event_t exp_ev;
		if (arst_n) begin
			if (in_valid && in_ready)
				predict_slot_events(cmd_t'(command), signal_id, filter_mask, timeout_ticks,
					slot_index);
			if (out_valid && out_ready) begin
				if (pending_events.size() == 0) begin
					err_count++;
					if (err_count <= MAX_REPORTS)
						$error("result slot %0d kind %0d with no event pending",
							hit_slot, event_kind);
				end else begin
					exp_ev = pending_events.pop_front();
					if (event_kind !== exp_ev.kind)
						report_mismatch("event_kind", SIG_W'(exp_ev.kind),
							SIG_W'(event_kind));
					if (hit_slot !== exp_ev.slot)
						report_mismatch("hit_slot", SIG_W'(exp_ev.slot), SIG_W'(hit_slot));
					if (delivered_signal !== exp_ev.sig)
						report_mismatch("delivered_signal", exp_ev.sig, delivered_signal);
					if (last_of_run !== exp_ev.last_flag)
						report_mismatch("last_of_run", SIG_W'(exp_ev.last_flag),
							SIG_W'(last_of_run));
				end
			end
		end
	end

	// Receiver: random stalls, or a long hold-off when one is requested.
	always @(posedge clk) begin
		if (hold_request != 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= out_idle_pct);
		end
	end

	// Stop a hung run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$error("no progress after %0d cycles", CYCLE_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Offer one item and hold it until accepted.
	task automatic send_item(input cmd_t cmd, input logic [SIG_W-1:0] sig,
			input logic [SIG_W-1:0] msk, input logic [TICKS_W-1:0] tmo,
			input logic [SLOT_W-1:0] idx);
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		command       <= cmd;
		signal_id     <= sig;
		filter_mask   <= msk;
		timeout_ticks <= tmo;
		slot_index    <= idx;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// Pause the input until every predicted event has come out.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (DRAIN_TAIL) @(posedge clk);
	endtask

	// Edge cases: match-all and exact masks, expiry, re-arm, removal.
	task automatic test_directed();
		in_idle_pct  = 27;
		out_idle_pct = 68;
		send_item(CMD_ADD, 32'h0000_0000, 32'h0000_0000, 16'd0, 4'd0);
		send_item(CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd1, 4'd15);
		// unused fields carry arbitrary values on signal and tick
		send_item(CMD_SIGNAL, 32'hFFFF_FFFF, $urandom, 16'hFFFF, 4'd5);
		send_item(CMD_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 4'd15);
		send_item(CMD_TICK, $urandom, $urandom, TICKS_W'($urandom), 4'd0);
		send_item(CMD_SIGNAL, 32'h0000_0000, 32'h0000_0000, 16'd0, 4'd0);
		send_item(CMD_ADD, 32'h0000_1200, 32'h0000_FF00, 16'd2, 4'd7);
		// match value outside its mask: never hits, still times out
		send_item(CMD_ADD, 32'h0000_00F0, 32'h0000_000F, 16'd3, 4'd3);
		send_item(CMD_SIGNAL, 32'hABCD_12EF, 32'h0, 16'd0, 4'd0);
		send_item(CMD_TICK, 32'h0, 32'h0, 16'd0, 4'd0);
		send_item(CMD_TICK, 32'h0, 32'h0, 16'd0, 4'd0);
		send_item(CMD_TICK, 32'h0, 32'h0, 16'd0, 4'd0);
		// re-arm a slot that already timed out
		send_item(CMD_SIGNAL, 32'h0000_1200, 32'h0, 16'd0, 4'd0);
		send_item(CMD_REMOVE, $urandom, $urandom, TICKS_W'($urandom), 4'd9);
		send_item(CMD_REMOVE, 32'h0, 32'h0, 16'd0, 4'd0);
		// overwrite a valid slot with the longest timeout
		send_item(CMD_ADD, 32'h1234_5678, 32'hFFFF_FFFF, 16'hFFFF, 4'd15);
		send_item(CMD_TICK, 32'h0, 32'h0, 16'd0, 4'd0);
		send_item(CMD_TICK, 32'h0, 32'h0, 16'd0, 4'd0);
		send_item(CMD_SIGNAL, 32'h1234_5678, 32'h0, 16'd0, 4'd0);
		send_item(CMD_REMOVE, 32'h0, 32'h0, 16'd0, 4'd15);
		send_item(CMD_REMOVE, 32'h0, 32'h0, 16'd0, 4'd7);
		send_item(CMD_REMOVE, 32'h0, 32'h0, 16'd0, 4'd3);
		send_item(CMD_TICK, 32'h0, 32'h0, 16'd0, 4'd0);
		wait_drained();
	endtask

	// Full table under a long output hold-off: every item yields 16 events.
	task automatic test_backpressure();
		in_idle_pct  = 0;
		out_idle_pct = 0;
		for (int i = 0; i < SLOT_COUNT; i++)
			send_item(CMD_ADD, 32'h0, 32'h0, 16'd1, SLOT_W'(i));
		hold_request = HOLD_CYCLES;
		for (int k = 0; k < 8; k++)
			send_item((k % 4 == 3) ? CMD_TICK : CMD_SIGNAL, $urandom, $urandom,
				TICKS_W'($urandom), SLOT_W'($urandom));
		wait_drained();
		for (int i = 0; i < SLOT_COUNT; i++)
			send_item(CMD_REMOVE, $urandom, $urandom, TICKS_W'($urandom), SLOT_W'(i));
		wait_drained();
	endtask

	// Mostly well-formed subscriptions and hits, with some noise.
	task automatic test_random(input int n_items, input int snd_idle, input int rcv_idle);
		cmd_t             cmd;
		logic [SIG_W-1:0] sig;
		logic [SIG_W-1:0] msk;
		logic [TICKS_W-1:0] tmo;
		logic [SLOT_W-1:0] idx;
		int               pick;
		in_idle_pct  = snd_idle;
		out_idle_pct = rcv_idle;
		for (int n = 0; n < n_items; n++) begin
			pick = $urandom_range(99);
			idx  = SLOT_W'($urandom_range(SLOT_COUNT - 1));
			sig  = $urandom;
			msk  = $urandom;
			tmo  = TICKS_W'($urandom);
			if (pick < 12) begin
				cmd = cmd_t'($urandom_range(3));
			end else if (pick < 36) begin
				cmd = CMD_ADD;
				case ($urandom_range(5))
					0: msk = 32'h0000_0000;
					1: msk = 32'hFFFF_FFFF;
					2: msk = 32'hFFFF_0000;
					3: msk = 32'h0000_00FF;
					4: msk = 32'hF0F0_F0F0;
					default: msk = $urandom;
				endcase
				case ($urandom_range(3))
					0: sig = 32'h1234_5678;
					1: sig = 32'hA5A5_C3C3;
					2: sig = 32'hFFFF_FFFF;
					default: sig = $urandom;
				endcase
				// keep most match values reachable through the mask
				if ($urandom_range(9) != 0)
					sig = sig & msk;
				pick = $urandom_range(99);
				if (pick < 15)
					tmo = '0;
				else if (pick < 85)
					tmo = TICKS_W'($urandom_range(5, 1));
			end else if (pick < 44) begin
				cmd = CMD_REMOVE;
			end else if (pick < 72) begin
				cmd = CMD_SIGNAL;
				if (sub_valid[idx])
					sig = (sub_value[idx] & sub_mask[idx]) | ($urandom & ~sub_mask[idx]);
			end else begin
				cmd = CMD_TICK;
			end
			send_item(cmd, sig, msk, tmo, idx);
		end
		wait_drained();
	endtask

	initial begin
		arst_n        <= 1'b0;
		in_valid      <= 1'b0;
		command       <= CMD_SIGNAL;
		signal_id     <= '0;
		filter_mask   <= '0;
		timeout_ticks <= '0;
		slot_index    <= '0;
		err_count     = 0;
		cycle_count   = 0;
		in_idle_pct   = 0;
		out_idle_pct  = 0;
		hold_request  = 0;
		hold_left     = 0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			sub_valid[i]   = 1'b0;
			sub_value[i]   = '0;
			sub_mask[i]    = '0;
			sub_timeout[i] = '0;
			sub_count[i]   = '0;
			sub_armed[i]   = 1'b0;
		end
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_backpressure();
		test_random(120, 27, 68);
		test_random(120, 68, 27);
		test_random(120, 0, 0);

		if (pending_events.size() != 0) begin
			err_count++;
			$error("%0d events never arrived", pending_events.size());
		end
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
